### sv/npste_pkg.sv
// Shared types, command codes and constants for the nearest point track error unit.
package npste_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic        [9:0]  point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] point_yaw;
    logic signed [31:0] point_curvature;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] signed_error;
    logic signed [31:0] nearest_curvature;
    logic signed [15:0] nearest_yaw;
    logic        [9:0]  nearest_index;
  } result_t;

  // Angles in units of 2^-24 rad
  localparam logic signed [31:0] PI_Q24     = 32'sd52707179;
  localparam logic signed [31:0] TWO_PI_Q24 = 32'sd105414358;
  localparam int unsigned        CORDIC_STEPS = 24;

  // Stored point: x, y, yaw, curvature
  localparam int unsigned POINT_W = 112;

  // Arctangent of 2^-i, rounded to 2^-24 rad
  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'sd13176795;
      5'd1:  r = 32'sd7778716;
      5'd2:  r = 32'sd4110060;
      5'd3:  r = 32'sd2086331;
      5'd4:  r = 32'sd1047214;
      5'd5:  r = 32'sd524117;
      5'd6:  r = 32'sd262123;
      5'd7:  r = 32'sd131069;
      5'd8:  r = 32'sd65536;
      5'd9:  r = 32'sd32768;
      5'd10: r = 32'sd16384;
      5'd11: r = 32'sd8192;
      5'd12: r = 32'sd4096;
      5'd13: r = 32'sd2048;
      5'd14: r = 32'sd1024;
      5'd15: r = 32'sd512;
      5'd16: r = 32'sd256;
      5'd17: r = 32'sd128;
      5'd18: r = 32'sd64;
      5'd19: r = 32'sd32;
      5'd20: r = 32'sd16;
      5'd21: r = 32'sd8;
      5'd22: r = 32'sd4;
      5'd23: r = 32'sd2;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### sv/npste_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module npste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/nearest_point_signed_track_error_unit.sv
// Top level: point store, nearest point scan, square root and bearing sequencer.
// Load transaction: written at the accept edge, busy stays low.
// Query transaction: busy through the scan of the points in use, the pipeline drain, fetch, load,
// 32 shared square root steps (the first 24 also CORDIC steps), output, and any angle wrap.
// Result strobe in the first cycle with busy low, never stalled; next item may start then.
// Synchronous active-high reset returns to idle and sets points_in_use to 1024.
module nearest_point_signed_track_error_unit #(
  parameter int unsigned PATH_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  npste_pkg::item_t       item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [10:0]            cfg_data,
  output logic                   strobe,
  output npste_pkg::result_t     result
);
  import npste_pkg::*;

  localparam int unsigned AW = $clog2(PATH_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_SOLVE = 7'b0100000,
    S_NORM  = 7'b1000000
  } state_t;

  state_t state;

  logic [10:0]        points_in_use;
  logic [AW:0]        n_scan;
  logic [AW:0]        scan_cnt;
  logic signed [31:0] rx, ry;

  // Point store
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [POINT_W-1:0]  ram_wdata, ram_rdata;
  logic signed [31:0]  rd_x, rd_y, rd_curv;
  logic signed [15:0]  rd_yaw;

  assign ram_wdata = {item.point_x, item.point_y, item.point_yaw, item.point_curvature};
  assign ram_waddr = AW'(item.point_index);
  assign ram_we    = start && !busy && (item.cmd == CMD_LOAD)
                     && ({22'd0, item.point_index} < 32'(PATH_DEPTH));
  assign {rd_x, rd_y, rd_yaw, rd_curv} = ram_rdata;

  npste_ram #(.WIDTH(POINT_W), .DEPTH(PATH_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  logic [AW-1:0] best_slot;
  assign ram_raddr = (state == S_SCAN) ? scan_cnt[AW-1:0] : best_slot;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // Scan pipeline registers
  logic          p1_v, p2_v, p3_v;
  logic [AW-1:0] p1_idx, p2_idx, p3_idx;
  logic [31:0]   p2_ax, p2_ay;
  logic [63:0]   p3_sx, p3_sy;
  logic [64:0]   best_sum;

  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        ax_c, ay_c;
  logic [64:0]        sum_c;

  assign dx_c  = 33'(rd_x) - 33'(rx);
  assign dy_c  = 33'(rd_y) - 33'(ry);
  assign ax_c  = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ay_c  = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign sum_c = 65'(p3_sx) + 65'(p3_sy);

  // Square root and CORDIC state
  logic [4:0]         step;
  logic [61:0]        sq_v;
  logic [62:0]        sq_res;
  logic               big;
  logic               at_origin;
  logic signed [35:0] cx, cy;
  logic signed [31:0] cz;
  logic signed [31:0] angle;
  logic signed [15:0] best_yaw;
  logic signed [31:0] best_curv;

  logic [62:0]        sq_bit, sq_try;
  logic [5:0]         sq_sh;
  logic signed [35:0] cx_sh, cy_sh;
  logic signed [31:0] atan_c;

  assign sq_sh  = 6'd62 - {step, 1'b0};
  assign sq_bit = 63'(1) << sq_sh;
  assign sq_try = sq_res + sq_bit;
  assign cx_sh  = cx >>> step;
  assign cy_sh  = cy >>> step;
  assign atan_c = atan_q24(step);

  logic [31:0]        distance;
  logic signed [31:0] err_c;

  assign distance = big ? 32'h8000_0000 : sq_res[31:0];
  assign err_c    = angle[31] ? 32'(-$signed({1'b0, distance}))
                              : (distance[31] ? 32'sh7fff_ffff : $signed(distance));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  // Sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      best_sum  <= '1;
      best_slot <= '0;
    end else begin
      strobe <= 1'b0;
      p1_v   <= 1'b0;
      p2_v   <= p1_v;
      p3_v   <= p2_v;
      // Keep the running minimum, first slot wins on ties
      if (p3_v && sum_c < best_sum) begin
        best_sum  <= sum_c;
        best_slot <= p3_idx;
      end
      unique case (state)
        S_IDLE: begin
          if (start && item.cmd == CMD_QUERY) begin
            rx       <= item.robot_x;
            ry       <= item.robot_y;
            scan_cnt <= '0;
            best_sum <= '1;
            best_slot <= '0;
            if (points_in_use == 11'd0) begin
              n_scan <= (AW+1)'(1);
            end else if (32'(points_in_use) > 32'(PATH_DEPTH)) begin
              n_scan <= (AW+1)'(PATH_DEPTH);
            end else begin
              n_scan <= (AW+1)'(points_in_use);
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          p1_v     <= 1'b1;
          p1_idx   <= scan_cnt[AW-1:0];
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == n_scan - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          best_yaw  <= rd_yaw;
          best_curv <= rd_curv;
          at_origin <= (dx_c == 33'sd0) && (dy_c == 33'sd0);
          big       <= best_sum[64] || (best_sum[63:62] != 2'b00);
          sq_v      <= best_sum[61:0];
          sq_res    <= '0;
          step      <= '0;
          // Turn by pi into the right half plane
          if (dx_c[32]) begin
            cx <= -36'(dx_c);
            cy <= -36'(dy_c);
            cz <= dy_c[32] ? -PI_Q24 : PI_Q24;
          end else begin
            cx <= 36'(dx_c);
            cy <= 36'(dy_c);
            cz <= '0;
          end
          state <= S_SOLVE;
        end
        S_SOLVE: begin
          // One square root digit
          if (64'(sq_v) >= 64'(sq_try)) begin
            sq_v   <= 62'(64'(sq_v) - 64'(sq_try));
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          // One CORDIC vectoring step
          if (32'(step) < CORDIC_STEPS) begin
            if (!cy[35]) begin
              cx <= cx + cy_sh;
              cy <= cy - cx_sh;
              cz <= cz + atan_c;
            end else begin
              cx <= cx - cy_sh;
              cy <= cy + cx_sh;
              cz <= cz - atan_c;
            end
          end
          step <= step + 1'b1;
          if (step == 5'd31) begin
            angle <= (32'(best_yaw) <<< 11) - (at_origin ? 32'sd0 : cz);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Wrap into minus pi to pi, one turn per cycle
          priority if (angle > PI_Q24) begin
            angle <= angle - TWO_PI_Q24;
          end else if (angle < -PI_Q24) begin
            angle <= angle + TWO_PI_Q24;
          end else begin
            result.signed_error      <= err_c;
            result.nearest_curvature <= best_curv;
            result.nearest_yaw       <= best_yaw;
            result.nearest_index     <= 10'(best_slot);
            strobe                   <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan datapath: difference magnitudes and squares
  always_ff @(posedge clk) begin
    p2_idx <= p1_idx;
    p2_ax  <= ax_c[31:0];
    p2_ay  <= ay_c[31:0];
    p3_idx <= p2_idx;
    p3_sx  <= 64'(p2_ax) * 64'(p2_ax);
    p3_sy  <= 64'(p2_ay) * 64'(p2_ay);
  end

  // Result only when back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy) else $error("result strobe while busy");

  // Query transaction enters the scan
  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_QUERY) |=> state == S_SCAN)
    else $error("query not started");

  // Scan never passes the slot count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt < n_scan)) else $error("scan out of range");

  // Best slot does not move during the square root / CORDIC steps
  a_best_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SOLVE) |=> $stable(best_slot)) else $error("best slot moved");

endmodule
